// ===== rtl/ufold_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the utf-8 punctuation folder
// no dependencies

package ufold_pkg;

    localparam int UFOLD_FIFO_DEPTH = 4;
    localparam int UFOLD_MAX_BYTES  = 4;

    localparam logic [7:0] MASK_LEAD2 = 8'hE0;
    localparam logic [7:0] CODE_LEAD2 = 8'hC0;
    localparam logic [7:0] MASK_LEAD3 = 8'hF0;
    localparam logic [7:0] CODE_LEAD3 = 8'hE0;
    localparam logic [7:0] MASK_LEAD4 = 8'hF8;
    localparam logic [7:0] CODE_LEAD4 = 8'hF0;

    localparam logic [15:0] CP_NBSP       = 16'h00A0;
    localparam logic [15:0] CP_LSQUO      = 16'h2018;
    localparam logic [15:0] CP_RSQUO      = 16'h2019;
    localparam logic [15:0] CP_LDQUO      = 16'h201C;
    localparam logic [15:0] CP_RDQUO      = 16'h201D;
    localparam logic [15:0] CP_EN_DASH    = 16'h2013;
    localparam logic [15:0] CP_EM_DASH    = 16'h2014;
    localparam logic [15:0] CP_ZERO_WIDTH = 16'h200B;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HYPHEN = 8'h2D;

    // results of one input byte
    typedef struct packed {
        logic [UFOLD_MAX_BYTES-1:0][7:0] data;
        logic [2:0]                      cnt;
        logic                            str_end;
    } ufold_burst_t;

endpackage

// ===== rtl/ufold_front.sv =====
`timescale 1ns / 1ps
// front end: accepts bytes, tracks the open sequence, builds result bursts
// depends on ufold_pkg

module ufold_front
    import ufold_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [7:0]   in_byte,
    input  logic         string_last,
    output logic         push_valid,
    input  logic         push_ready,
    output ufold_burst_t push_burst
);

    logic [23:0] held_reg, held_next;
    logic [2:0]  len_reg, len_next;
    logic [1:0]  gath_reg, gath_next;
    logic        accept;
    logic [7:0]  b0, b1, b2;
    logic [15:0] cp2, cp3;

    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;
    assign b0       = held_reg[7:0];
    assign b1       = held_reg[15:8];
    assign b2       = held_reg[23:16];
    assign cp2      = {5'd0, b0[4:0], in_byte[5:0]};
    assign cp3      = {b0[3:0], b1[5:0], in_byte[5:0]};

    always_comb
    begin
        push_burst = '0;
        held_next  = held_reg;
        len_next   = len_reg;
        gath_next  = gath_reg;
        if (len_reg != 3'd0)
        begin
            if ({1'b0, gath_reg} + 3'd1 == len_reg)
            begin
                unique case (len_reg)
                    3'd2:
                    begin
                        if (cp2 == CP_NBSP)
                        begin
                            push_burst.data[0] = CH_SPACE;
                            push_burst.cnt     = 3'd1;
                        end
                        else
                        begin
                            push_burst.data[0] = b0;
                            push_burst.data[1] = in_byte;
                            push_burst.cnt     = 3'd2;
                        end
                    end
                    3'd3:
                    begin
                        priority if (cp3 == CP_LSQUO || cp3 == CP_RSQUO)
                        begin
                            push_burst.data[0] = CH_APOS;
                            push_burst.cnt     = 3'd1;
                        end
                        else if (cp3 == CP_LDQUO || cp3 == CP_RDQUO)
                        begin
                            push_burst.data[0] = CH_QUOTE;
                            push_burst.cnt     = 3'd1;
                        end
                        else if (cp3 == CP_EN_DASH || cp3 == CP_EM_DASH)
                        begin
                            push_burst.data[0] = CH_HYPHEN;
                            push_burst.cnt     = 3'd1;
                        end
                        else if (cp3 == CP_ZERO_WIDTH)
                        begin
                            push_burst.cnt = 3'd0;
                        end
                        else
                        begin
                            push_burst.data[0] = b0;
                            push_burst.data[1] = b1;
                            push_burst.data[2] = in_byte;
                            push_burst.cnt     = 3'd3;
                        end
                    end
                    default:
                    begin
                        push_burst.data[0] = b0;
                        push_burst.data[1] = b1;
                        push_burst.data[2] = b2;
                        push_burst.data[3] = in_byte;
                        push_burst.cnt     = 3'd4;
                    end
                endcase
                held_next = '0;
                len_next  = 3'd0;
                gath_next = 2'd0;
            end
            else
            begin
                unique case (gath_reg)
                    2'd1:    held_next[15:8]  = in_byte;
                    2'd2:    held_next[23:16] = in_byte;
                    default: held_next        = held_reg;
                endcase
                gath_next = gath_reg + 2'd1;
            end
        end
        else
        begin
            held_next = '0;
            len_next  = 3'd0;
            gath_next = 2'd0;
            priority if (!in_byte[7])
            begin
                push_burst.data[0] = in_byte;
                push_burst.cnt     = 3'd1;
            end
            else if ((in_byte & MASK_LEAD2) == CODE_LEAD2)
            begin
                held_next = {16'd0, in_byte};
                len_next  = 3'd2;
                gath_next = 2'd1;
            end
            else if ((in_byte & MASK_LEAD3) == CODE_LEAD3)
            begin
                held_next = {16'd0, in_byte};
                len_next  = 3'd3;
                gath_next = 2'd1;
            end
            else if ((in_byte & MASK_LEAD4) == CODE_LEAD4)
            begin
                held_next = {16'd0, in_byte};
                len_next  = 3'd4;
                gath_next = 2'd1;
            end
            else
            begin
                push_burst.cnt = 3'd0;
            end
        end
        if (string_last)
        begin
            held_next = '0;
            len_next  = 3'd0;
            gath_next = 2'd0;
        end
        push_burst.str_end = string_last;
    end

    assign push_valid = accept && (push_burst.cnt != 3'd0 || string_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            len_reg  <= 3'd0;
            gath_reg <= 2'd0;
        end
        else if (accept)
        begin
            held_reg <= held_next;
            len_reg  <= len_next;
            gath_reg <= gath_next;
        end
    end

endmodule

// ===== rtl/ufold_fifo.sv =====
`timescale 1ns / 1ps
// short burst queue between front and back end
// depends on ufold_pkg

module ufold_fifo
    import ufold_pkg::*;
#(
    parameter int DEPTH = UFOLD_FIFO_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    output logic         push_ready,
    input  ufold_burst_t push_burst,
    output logic         pop_valid,
    input  logic         pop_ready,
    output ufold_burst_t pop_burst
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    ufold_burst_t    slot_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            push, pop;

    assign push_ready = (cnt_reg != FULL_CNT);
    assign pop_valid  = (cnt_reg != '0);
    assign pop_burst  = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_burst;
        end
    end

endmodule

// ===== rtl/ufold_back.sv =====
`timescale 1ns / 1ps
// back end: unrolls each burst into single result transactions
// depends on ufold_pkg

module ufold_back
    import ufold_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         pop_valid,
    output logic         pop_ready,
    input  ufold_burst_t pop_burst,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [7:0]   out_byte,
    output logic         byte_valid,
    output logic         string_end,
    output logic         run_last
);

    ufold_burst_t cur_reg;
    logic         cur_valid_reg, cur_valid_next;
    logic [1:0]   idx_reg, idx_next;
    logic         out_valid_reg;
    logic [7:0]   out_byte_reg;
    logic         byte_valid_reg, string_end_reg, run_last_reg;
    logic         load_ok, emit, cur_last;

    assign load_ok   = !out_valid_reg || out_ready;
    assign emit      = load_ok && cur_valid_reg;
    assign cur_last  = ({1'b0, idx_reg} + 3'd1 >= cur_reg.cnt);
    assign pop_ready = !cur_valid_reg || (emit && cur_last);

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (emit)
        begin
            idx_next = idx_reg + 2'd1;
            if (cur_last)
            begin
                cur_valid_next = 1'b0;
            end
        end
        if (pop_valid && pop_ready)
        begin
            cur_valid_next = 1'b1;
            idx_next       = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            if (load_ok)
            begin
                out_valid_reg <= cur_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_valid && pop_ready)
        begin
            cur_reg <= pop_burst;
        end
        if (emit)
        begin
            out_byte_reg   <= (cur_reg.cnt != 3'd0) ? cur_reg.data[idx_reg] : 8'd0;
            byte_valid_reg <= (cur_reg.cnt != 3'd0);
            string_end_reg <= cur_reg.str_end && cur_last;
            run_last_reg   <= cur_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign byte_valid = byte_valid_reg;
    assign string_end = string_end_reg;
    assign run_last   = run_last_reg;

endmodule

// ===== rtl/utf8_punctuation_folder.sv =====
`timescale 1ns / 1ps
// path: a result passes through the burst queue, the back end's burst register
// and the output register; throughput: one input byte and one result per cycle
// while out_ready holds; a byte that yields two to four results holds the back
// end until all are sent, and the burst queue stalls the input once it fills
// reset: asynchronous, active low; clears sequence state, queue and output
// top level of the utf-8 punctuation folder; depends on ufold_pkg, ufold_front,
// ufold_fifo and ufold_back

module utf8_punctuation_folder
    import ufold_pkg::*;
#(
    parameter int FIFO_DEPTH = UFOLD_FIFO_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       string_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       string_end,
    output logic       run_last
);

    logic         push_valid, push_ready, pop_valid, pop_ready;
    ufold_burst_t push_burst, pop_burst;

    ufold_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .string_last (string_last),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_burst  (push_burst)
    );

    ufold_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_burst (push_burst),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_burst  (pop_burst)
    );

    ufold_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_burst  (pop_burst),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .string_end (string_end),
        .run_last   (run_last)
    );

endmodule

// ===== rtl/ufold_check.sv =====
`timescale 1ns / 1ps
// port-level checks of the utf-8 punctuation folder, bound to the top level
// depends on utf8_punctuation_folder

module ufold_check (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] in_byte,
    input logic       string_last,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       byte_valid,
    input logic       string_end,
    input logic       run_last
);

    // end of string always closes the run of its byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && string_end |-> run_last)
        else $error("string_end without run_last");

    // an end marker carries no byte and ends the string
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> string_end && run_last && out_byte == 8'd0)
        else $error("malformed end marker");

    // a stalled transaction stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped under stall");

    // a stalled transaction keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_byte) && $stable(byte_valid)
            && $stable(string_end) && $stable(run_last))
        else $error("payload changed under stall");

    // a stalled input transaction stays offered with its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_byte) && $stable(string_last))
        else $error("input transaction changed under stall");

endmodule

bind utf8_punctuation_folder ufold_check u_check (.*);
